// ===== design/tzbm_pkg.sv =====
// ----------------------------------------------------------------------------
// tzbm_pkg
// Shared widths, codes and types of the touch zone button mapper.
// ----------------------------------------------------------------------------
package tzbm_pkg;

  localparam int unsigned MAX_TOUCHES = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_TOUCHES + 1);

  localparam int unsigned ID_W       = 32;
  localparam int unsigned X_W        = 12;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned MIN_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic CMD_TOUCH     = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS  = 2'd3;

  localparam logic [MASK_W-1:0] LEFT_MASK_RST  = 32'd2;
  localparam logic [MASK_W-1:0] RIGHT_MASK_RST = 32'd1;
  localparam logic [X_W-1:0]    SPLIT_X_RST    = 12'd640;
  localparam logic [MIN_W-1:0]  MIN_TICKS_RST  = 32'd960000;

  typedef struct packed {
    logic [MASK_W-1:0] left_mask;
    logic [MASK_W-1:0] right_mask;
    logic [X_W-1:0]    split_x;
    logic [MIN_W-1:0]  min_ticks;
  } cfg_t;

  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
  } cand_t;

  // both_*: picks when neither tracked finger survives
  // only_r: right pick when the left finger survives
  // only_l: left pick when the right finger survives
  typedef struct packed {
    logic  seen_l;
    logic  seen_r;
    logic  empty;
    cand_t both_l;
    cand_t both_r;
    cand_t only_r;
    cand_t only_l;
  } frame_sum_t;

  typedef struct packed {
    logic            l_trk;
    logic            r_trk;
    logic [ID_W-1:0] l_fid;
    logic [ID_W-1:0] r_fid;
  } track_t;

  typedef struct packed {
    logic [MASK_W-1:0] buttons;
    logic              l_on;
    logic              r_on;
  } res_t;

endpackage

// ===== design/tzbm_in_if.sv =====
// ----------------------------------------------------------------------------
// tzbm_in_if
// Touch item channel: touch points and frame-end items.
// ----------------------------------------------------------------------------
interface tzbm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [tzbm_pkg::ID_W-1:0]    touch_id;
  logic [tzbm_pkg::X_W-1:0]     x_pos;
  logic [tzbm_pkg::TICK_W-1:0]  now_tick;

  modport source (output valid, cmd, touch_id, x_pos, now_tick, input ready);
  modport sink   (input valid, cmd, touch_id, x_pos, now_tick, output ready);
endinterface

// ===== design/tzbm_out_if.sv =====
// ----------------------------------------------------------------------------
// tzbm_out_if
// Result channel: button state per frame.
// ----------------------------------------------------------------------------
interface tzbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tzbm_pkg::MASK_W-1:0] buttons;
  logic                        left_active;
  logic                        right_active;

  modport source (output valid, buttons, left_active, right_active, input ready);
  modport sink   (input valid, buttons, left_active, right_active, output ready);
endinterface

// ===== design/tzbm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tzbm_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface tzbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tzbm_pkg::CFG_IDX_W-1:0]  index;
  logic [tzbm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tzbm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tzbm_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module tzbm_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  tzbm_cfg_if.sink          cfg_ch,
  output tzbm_pkg::cfg_t    cfg
);

  tzbm_pkg::cfg_t cfg_r;
  tzbm_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tzbm_pkg::REG_LEFT_MASK:  cfg_nxt.left_mask  = cfg_ch.data;
        tzbm_pkg::REG_RIGHT_MASK: cfg_nxt.right_mask = cfg_ch.data;
        tzbm_pkg::REG_SPLIT_X:    cfg_nxt.split_x    = cfg_ch.data[tzbm_pkg::X_W-1:0];
        tzbm_pkg::REG_MIN_TICKS:  cfg_nxt.min_ticks  = cfg_ch.data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_mask  <= tzbm_pkg::LEFT_MASK_RST;
      cfg_r.right_mask <= tzbm_pkg::RIGHT_MASK_RST;
      cfg_r.split_x    <= tzbm_pkg::SPLIT_X_RST;
      cfg_r.min_ticks  <= tzbm_pkg::MIN_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/tzbm_touch_acc.sv =====
// ----------------------------------------------------------------------------
// tzbm_touch_acc
// Folds the touches of a frame into seen flags and per-case finger picks.
// ----------------------------------------------------------------------------
module tzbm_touch_acc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        touch_en,
  input  logic                        frame_clr,
  input  logic [tzbm_pkg::ID_W-1:0]   touch_id,
  input  logic [tzbm_pkg::X_W-1:0]    x_pos,
  input  logic [tzbm_pkg::X_W-1:0]    split_x,
  input  tzbm_pkg::track_t            trk,
  output tzbm_pkg::frame_sum_t        sum
);

  logic [tzbm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       seen_l_r, seen_l_nxt;
  logic                       seen_r_r, seen_r_nxt;
  tzbm_pkg::cand_t            both_l_r, both_l_nxt;
  tzbm_pkg::cand_t            both_r_r, both_r_nxt;
  tzbm_pkg::cand_t            only_r_r, only_r_nxt;
  tzbm_pkg::cand_t            only_l_r, only_l_nxt;

  logic take;
  logic is_left;
  logic set_both_l, set_both_r, set_only_r, set_only_l;

  assign take    = touch_en && (cnt_r < tzbm_pkg::CNT_W'(tzbm_pkg::MAX_TOUCHES));
  assign is_left = x_pos < split_x;

  assign set_both_l = take && is_left && !both_l_r.vld &&
                      !(both_r_r.vld && touch_id == both_r_r.id);
  assign set_both_r = take && !is_left && !both_r_r.vld &&
                      !(both_l_r.vld && touch_id == both_l_r.id);
  assign set_only_r = take && !is_left && !only_r_r.vld && (touch_id != trk.l_fid);
  assign set_only_l = take && is_left && !only_l_r.vld && (touch_id != trk.r_fid);

  always_comb begin
    cnt_nxt    = cnt_r;
    seen_l_nxt = seen_l_r;
    seen_r_nxt = seen_r_r;
    both_l_nxt = both_l_r;
    both_r_nxt = both_r_r;
    only_r_nxt = only_r_r;
    only_l_nxt = only_l_r;
    if (frame_clr) begin
      cnt_nxt        = '0;
      seen_l_nxt     = 1'b0;
      seen_r_nxt     = 1'b0;
      both_l_nxt.vld = 1'b0;
      both_r_nxt.vld = 1'b0;
      only_r_nxt.vld = 1'b0;
      only_l_nxt.vld = 1'b0;
    end else if (take) begin
      cnt_nxt    = cnt_r + 1'b1;
      seen_l_nxt = seen_l_r || (trk.l_trk && touch_id == trk.l_fid);
      seen_r_nxt = seen_r_r || (trk.r_trk && touch_id == trk.r_fid);
      if (set_both_l) both_l_nxt = '{vld: 1'b1, id: touch_id};
      if (set_both_r) both_r_nxt = '{vld: 1'b1, id: touch_id};
      if (set_only_r) only_r_nxt = '{vld: 1'b1, id: touch_id};
      if (set_only_l) only_l_nxt = '{vld: 1'b1, id: touch_id};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      seen_l_r     <= 1'b0;
      seen_r_r     <= 1'b0;
      both_l_r.vld <= 1'b0;
      both_r_r.vld <= 1'b0;
      only_r_r.vld <= 1'b0;
      only_l_r.vld <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      seen_l_r <= seen_l_nxt;
      seen_r_r <= seen_r_nxt;
      both_l_r <= both_l_nxt;
      both_r_r <= both_r_nxt;
      only_r_r <= only_r_nxt;
      only_l_r <= only_l_nxt;
    end
  end

  assign sum.seen_l = seen_l_r;
  assign sum.seen_r = seen_r_r;
  assign sum.empty  = (cnt_r == '0);
  assign sum.both_l = both_l_r;
  assign sum.both_r = both_r_r;
  assign sum.only_r = only_r_r;
  assign sum.only_l = only_l_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tzbm_pkg::CNT_W'(tzbm_pkg::MAX_TOUCHES))
    else $error("touch count above limit");

  a_pick_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    both_l_r.vld && both_r_r.vld |-> both_l_r.id != both_r_r.id)
    else $error("same finger picked for both halves");

endmodule

// ===== design/tzbm_tracker.sv =====
// ----------------------------------------------------------------------------
// tzbm_tracker
// Per-half finger tracking, press timing and button result at frame end.
// ----------------------------------------------------------------------------
module tzbm_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         frame_en,
  input  logic [tzbm_pkg::TICK_W-1:0]  now_tick,
  input  tzbm_pkg::frame_sum_t         sum,
  input  tzbm_pkg::cfg_t               cfg,
  output tzbm_pkg::track_t             trk,
  output tzbm_pkg::res_t               res
);

  logic                        wait_r, wait_nxt;
  logic                        l_trk_r, l_trk_nxt;
  logic                        r_trk_r, r_trk_nxt;
  logic [tzbm_pkg::ID_W-1:0]   l_fid_r, l_fid_nxt;
  logic [tzbm_pkg::ID_W-1:0]   r_fid_r, r_fid_nxt;
  logic [tzbm_pkg::TICK_W-1:0] l_start_r, l_start_nxt;
  logic [tzbm_pkg::TICK_W-1:0] r_start_r, r_start_nxt;

  logic                        l_keep, r_keep;
  logic                        lt, rt;
  logic [tzbm_pkg::ID_W-1:0]   lf, rf;
  logic [tzbm_pkg::TICK_W-1:0] ls, rs;
  logic [tzbm_pkg::TICK_W-1:0] l_el, r_el;
  logic                        l_hold, r_hold;
  logic                        l_on, r_on;
  logic [tzbm_pkg::MASK_W-1:0] rmask;

  assign l_keep = l_trk_r && sum.seen_l;
  assign r_keep = r_trk_r && sum.seen_r;

  always_comb begin
    lt = l_keep;
    lf = l_fid_r;
    rt = r_keep;
    rf = r_fid_r;
    case ({l_keep, r_keep})
      2'b00: begin
        lt = sum.both_l.vld;
        lf = sum.both_l.vld ? sum.both_l.id : l_fid_r;
        rt = sum.both_r.vld;
        rf = sum.both_r.vld ? sum.both_r.id : r_fid_r;
      end
      2'b10: begin
        rt = sum.only_r.vld;
        rf = sum.only_r.vld ? sum.only_r.id : r_fid_r;
      end
      2'b01: begin
        lt = sum.only_l.vld;
        lf = sum.only_l.vld ? sum.only_l.id : l_fid_r;
      end
      default: begin
        lt = l_keep;
        rt = r_keep;
      end
    endcase
  end

  // start of zero marks no press
  assign ls     = (lt && !l_trk_r) ? now_tick : l_start_r;
  assign rs     = (rt && !r_trk_r) ? now_tick : r_start_r;
  assign l_el   = now_tick - ls;
  assign r_el   = now_tick - rs;
  assign l_hold = (ls != '0) && (l_el < {{(tzbm_pkg::TICK_W-tzbm_pkg::MIN_W){1'b0}},
                                          cfg.min_ticks});
  assign r_hold = (rs != '0) && (r_el < {{(tzbm_pkg::TICK_W-tzbm_pkg::MIN_W){1'b0}},
                                          cfg.min_ticks});
  assign l_on   = lt || l_hold;
  assign r_on   = rt || r_hold;
  assign rmask  = (cfg.right_mask == cfg.left_mask) ? '0 : cfg.right_mask;

  always_comb begin
    wait_nxt    = wait_r;
    l_trk_nxt   = l_trk_r;
    r_trk_nxt   = r_trk_r;
    l_fid_nxt   = l_fid_r;
    r_fid_nxt   = r_fid_r;
    l_start_nxt = l_start_r;
    r_start_nxt = r_start_r;
    res         = '0;
    if (frame_en) begin
      if (wait_r) begin
        wait_nxt = !sum.empty;
      end else begin
        l_trk_nxt   = lt;
        r_trk_nxt   = rt;
        l_fid_nxt   = lf;
        r_fid_nxt   = rf;
        l_start_nxt = l_on ? ls : '0;
        r_start_nxt = r_on ? rs : '0;
        res.buttons = (l_on ? cfg.left_mask : '0) | (r_on ? rmask : '0);
        res.l_on    = l_on;
        res.r_on    = r_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r    <= 1'b1;
      l_trk_r   <= 1'b0;
      r_trk_r   <= 1'b0;
      l_fid_r   <= '0;
      r_fid_r   <= '0;
      l_start_r <= '0;
      r_start_r <= '0;
    end else begin
      wait_r    <= wait_nxt;
      l_trk_r   <= l_trk_nxt;
      r_trk_r   <= r_trk_nxt;
      l_fid_r   <= l_fid_nxt;
      r_fid_r   <= r_fid_nxt;
      l_start_r <= l_start_nxt;
      r_start_r <= r_start_nxt;
    end
  end

  assign trk.l_trk = l_trk_r;
  assign trk.r_trk = r_trk_r;
  assign trk.l_fid = l_fid_r;
  assign trk.r_fid = r_fid_r;

  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    frame_en && wait_r |-> res.buttons == '0 && !res.l_on && !res.r_on)
    else $error("nonzero result while waiting for release");

  a_wait_no_track: assert property (@(posedge clk) disable iff (!rst_n)
    wait_r |-> !l_trk_r && !r_trk_r)
    else $error("finger tracked while waiting for release");

  a_fid_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    l_trk_r && r_trk_r |-> l_fid_r != r_fid_r)
    else $error("one finger tracked on both halves");

endmodule

// ===== design/touch_zone_button_mapper.sv =====
// ----------------------------------------------------------------------------
// touch_zone_button_mapper
// Maps touch frames onto two screen-half buttons.
//
//   channel  dir  transfer                   payload
//   in_ch    in   touch point or frame end   cmd, touch_id, x_pos, now_tick
//   out_ch   out  one per frame end          buttons, left_active, right_active
//   cfg_ch   in   one register write         index, data
//
// One item per cycle while no held result stalls a frame end; a frame-end
// result passes through the input stage register, then the result register.
// Reset is synchronous; output stays zero until a frame with no touches.
// A held result stalls a staged frame end and input behind it; touches advance.
// ----------------------------------------------------------------------------
module touch_zone_button_mapper (
  input  logic       clk,
  input  logic       rst_n,
  tzbm_in_if.sink    in_ch,
  tzbm_out_if.source out_ch,
  tzbm_cfg_if.sink   cfg_ch
);

  logic                        stg_vld_r;
  logic                        stg_cmd_r;
  logic [tzbm_pkg::ID_W-1:0]   stg_id_r;
  logic [tzbm_pkg::X_W-1:0]    stg_x_r;
  logic [tzbm_pkg::TICK_W-1:0] stg_now_r;

  logic                        out_vld_r;
  tzbm_pkg::res_t              out_res_r;

  logic                        adv;
  logic                        touch_en;
  logic                        frame_en;
  logic                        in_take;

  tzbm_pkg::cfg_t              cfg;
  tzbm_pkg::track_t            trk;
  tzbm_pkg::frame_sum_t        sum;
  tzbm_pkg::res_t              res;

  assign adv = stg_vld_r &&
               ((stg_cmd_r == tzbm_pkg::CMD_TOUCH) || !out_vld_r || out_ch.ready);
  assign touch_en    = adv && (stg_cmd_r == tzbm_pkg::CMD_TOUCH);
  assign frame_en    = adv && (stg_cmd_r == tzbm_pkg::CMD_FRAME_END);
  assign in_ch.ready = !stg_vld_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  tzbm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tzbm_touch_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .touch_en  (touch_en),
    .frame_clr (frame_en),
    .touch_id  (stg_id_r),
    .x_pos     (stg_x_r),
    .split_x   (cfg.split_x),
    .trk       (trk),
    .sum       (sum)
  );

  tzbm_tracker u_trk (
    .clk      (clk),
    .rst_n    (rst_n),
    .frame_en (frame_en),
    .now_tick (stg_now_r),
    .sum      (sum),
    .cfg      (cfg),
    .trk      (trk),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        stg_vld_r <= 1'b1;
      end else if (adv) begin
        stg_vld_r <= 1'b0;
      end
      if (frame_en) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_cmd_r <= in_ch.cmd;
      stg_id_r  <= in_ch.touch_id;
      stg_x_r   <= in_ch.x_pos;
      stg_now_r <= in_ch.now_tick;
    end
    if (frame_en) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.buttons      = out_res_r.buttons;
  assign out_ch.left_active  = out_res_r.l_on;
  assign out_ch.right_active = out_res_r.r_on;

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && stg_cmd_r == tzbm_pkg::CMD_FRAME_END && out_vld_r && !out_ch.ready
    |-> !in_ch.ready && !frame_en)
    else $error("frame end overran a held result");

  a_touch_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    touch_en && out_vld_r && out_ch.ready |=> !out_vld_r)
    else $error("touch item produced a result");

endmodule

// ===== sim/touch_zone_button_mapper_tb.sv =====
// ----------------------------------------------------------------------------
// touch_zone_button_mapper_tb
// Self-checking bench for the two-half touch button mapper. A short table of
// directed frames covers reset release, extremes, press at tick zero, tick
// wrap and duplicate ids. Random frames follow, built from a small pool of
// persistent fingers plus noise and oversized frames, across several register
// settings and idle profiles. Every frame-end result is checked field by field
// against a behavioral prediction of the tracking state or a fixed directed value.
// ----------------------------------------------------------------------------
module touch_zone_button_mapper_tb;

  typedef struct {
    logic                        cmd;
    logic [tzbm_pkg::ID_W-1:0]   id;
    logic [tzbm_pkg::X_W-1:0]    x;
    logic [tzbm_pkg::TICK_W-1:0] tick;
  } touch_item_t;

  typedef struct {
    touch_item_t    it;
    logic           fixed;
    tzbm_pkg::res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tzbm_in_if  in_ch();
  tzbm_out_if out_ch();
  tzbm_cfg_if cfg_ch();

  touch_zone_button_mapper u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // tracking state mirror
  tzbm_pkg::cfg_t              zone_cfg;
  logic                        wait_rel;
  logic                        l_trk, r_trk;
  logic [tzbm_pkg::ID_W-1:0]   l_fid, r_fid;
  logic [tzbm_pkg::TICK_W-1:0] l_start, r_start;
  int unsigned                 frame_cnt;
  logic [tzbm_pkg::ID_W-1:0]   frame_ids [tzbm_pkg::MAX_TOUCHES];
  logic [tzbm_pkg::X_W-1:0]    frame_xs  [tzbm_pkg::MAX_TOUCHES];

  tzbm_pkg::res_t pending_buttons[$];
  int unsigned    mismatch_cnt;
  int unsigned    items_sent;
  int unsigned    send_idle_pct;
  int unsigned    rcv_stall_pct;

  logic [tzbm_pkg::TICK_W-1:0] cur_tick;
  int unsigned                 tick_step_max;
  logic [tzbm_pkg::ID_W-1:0]   pool_id [4];
  logic [tzbm_pkg::X_W-1:0]    pool_x  [4];
  dir_row_t                    dir_rows[$];

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("touch_zone_button_mapper: mismatch");
    $finish;
  end

  function automatic logic id_present(input logic [tzbm_pkg::ID_W-1:0] id,
                                      input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (frame_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic held(input logic [tzbm_pkg::TICK_W-1:0] start,
                                input logic [tzbm_pkg::TICK_W-1:0] now);
    logic [tzbm_pkg::TICK_W-1:0] elapsed;
    elapsed = now - start;
    return (start != '0) && (elapsed < {32'd0, zone_cfg.min_ticks});
  endfunction

  // Advances the mirror by one accepted item; returns 1 when a result is due.
  function automatic logic predict_buttons(input touch_item_t it, output tzbm_pkg::res_t res);
    int unsigned                 n;
    logic                        was_l, was_r, l_on, r_on;
    logic [tzbm_pkg::MASK_W-1:0] rmask;
    res = '0;
    if (it.cmd == tzbm_pkg::CMD_TOUCH) begin
      if (frame_cnt < tzbm_pkg::MAX_TOUCHES) begin
        frame_ids[frame_cnt] = it.id;
        frame_xs[frame_cnt]  = it.x;
        frame_cnt++;
      end
      return 1'b0;
    end
    n = frame_cnt;
    frame_cnt = 0;
    if (wait_rel) begin
      if (n == 0) wait_rel = 1'b0;
      return 1'b1;
    end
    was_l = l_trk;
    was_r = r_trk;
    if (l_trk && !id_present(l_fid, n)) l_trk = 1'b0;
    if (r_trk && !id_present(r_fid, n)) r_trk = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ((l_trk && frame_ids[i] == l_fid) || (r_trk && frame_ids[i] == r_fid)) continue;
      if (frame_xs[i] < zone_cfg.split_x) begin
        if (!l_trk) begin
          l_trk = 1'b1;
          l_fid = frame_ids[i];
        end
      end else if (!r_trk) begin
        r_trk = 1'b1;
        r_fid = frame_ids[i];
      end
    end
    if (l_trk && !was_l) l_start = it.tick;
    if (r_trk && !was_r) r_start = it.tick;
    l_on = l_trk || held(l_start, it.tick);
    r_on = r_trk || held(r_start, it.tick);
    if (!l_on) l_start = '0;
    if (!r_on) r_start = '0;
    rmask = (zone_cfg.right_mask == zone_cfg.left_mask) ? '0 : zone_cfg.right_mask;
    res.buttons = (l_on ? zone_cfg.left_mask : '0) | (r_on ? rmask : '0);
    res.l_on    = l_on;
    res.r_on    = r_on;
    return 1'b1;
  endfunction

  function automatic touch_item_t touch(input logic [tzbm_pkg::ID_W-1:0] id,
                                        input logic [tzbm_pkg::X_W-1:0] x);
    touch_item_t it;
    it.cmd  = tzbm_pkg::CMD_TOUCH;
    it.id   = id;
    it.x    = x;
    it.tick = {$urandom, $urandom};
    return it;
  endfunction

  function automatic touch_item_t frame_end(input logic [tzbm_pkg::TICK_W-1:0] tick);
    touch_item_t it;
    it.cmd  = tzbm_pkg::CMD_FRAME_END;
    it.id   = $urandom;
    it.x    = tzbm_pkg::X_W'($urandom_range(0, 4095));
    it.tick = tick;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic send_item(input touch_item_t it, input logic fixed,
                           input tzbm_pkg::res_t want);
    tzbm_pkg::res_t pred;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.cmd      = it.cmd;
    in_ch.touch_id = it.id;
    in_ch.x_pos    = it.x;
    in_ch.now_tick = it.tick;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_buttons(it, pred)) pending_buttons.push_back(fixed ? want : pred);
    items_sent++;
  endtask

  // hold off until every expected result is back, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_buttons.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tzbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tzbm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      tzbm_pkg::REG_LEFT_MASK:  zone_cfg.left_mask  = val;
      tzbm_pkg::REG_RIGHT_MASK: zone_cfg.right_mask = val;
      tzbm_pkg::REG_SPLIT_X:    zone_cfg.split_x    = val[tzbm_pkg::X_W-1:0];
      tzbm_pkg::REG_MIN_TICKS:  zone_cfg.min_ticks  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [tzbm_pkg::X_W-1:0] pick_x();
    case ($urandom_range(3))
      1:       return zone_cfg.split_x;
      2:       return (zone_cfg.split_x != 0) ? zone_cfg.split_x - 1'b1 : '0;
      default: return tzbm_pkg::X_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [tzbm_pkg::ID_W-1:0] pick_id();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic start_phase(input int unsigned p);
    logic [tzbm_pkg::MASK_W-1:0] lm, rm;
    logic [tzbm_pkg::X_W-1:0]    sx;
    logic [tzbm_pkg::MIN_W-1:0]  mt;
    settle();
    lm = $urandom;
    rm = $urandom;
    sx = tzbm_pkg::X_W'($urandom_range(1, 4094));
    mt = $urandom_range(1, 40);
    case (p % 8)
      1: begin
        lm = '1; rm = '0; sx = '0; mt = '0;
      end
      2: begin
        rm = lm; sx = '1; mt = '1;
      end
      3: begin
        lm = '0; rm = '1;
      end
      4: begin
        sx = 12'd2048; mt = 32'd3;
      end
      5: mt = $urandom_range(0, 60);
      default: ;
    endcase
    write_reg(tzbm_pkg::REG_LEFT_MASK, lm);
    write_reg(tzbm_pkg::REG_RIGHT_MASK, rm);
    write_reg(tzbm_pkg::REG_SPLIT_X, {20'($urandom_range(0, 1048575)), sx});
    write_reg(tzbm_pkg::REG_MIN_TICKS, mt);
    case (p % 4)
      0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; rcv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rcv_stall_pct = 60; end
      default: begin send_idle_pct = 17; rcv_stall_pct = 17; end
    endcase
    tick_step_max = $urandom_range(2, 12);
    for (int k = 0; k < 4; k++) begin
      pool_id[k] = ($urandom_range(3) == 0) ? pick_id()
                                            : tzbm_pkg::ID_W'($urandom_range(0, 9));
      pool_x[k]  = pick_x();
    end
  endtask

  task automatic send_frame();
    int unsigned    cnt, first, k;
    tzbm_pkg::res_t none;
    none = '0;
    if ($urandom_range(99) < 5) begin
      cnt = $urandom_range(14, 20);
      for (k = 0; k < cnt; k++) begin
        if ($urandom_range(1)) send_item(touch(pool_id[$urandom_range(3)], pick_x()), 1'b0, none);
        else send_item(touch(pick_id(), pick_x()), 1'b0, none);
      end
    end else begin
      first = $urandom_range(3);
      for (k = 0; k < 4; k++) begin
        if ($urandom_range(99) < 75)
          send_item(touch(pool_id[(first + k) % 4], pool_x[(first + k) % 4]), 1'b0, none);
        if ($urandom_range(99) < 15)
          send_item(touch(tzbm_pkg::ID_W'($urandom_range(0, 9)), pick_x()), 1'b0, none);
      end
    end
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(99) < 10) pool_x[k] = pick_x();
    end
    case ($urandom_range(99))
      0, 1, 2: cur_tick = {$urandom, $urandom};
      3:       cur_tick = {32'hFFFF_FFFF, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))};
      default: cur_tick = cur_tick + tzbm_pkg::TICK_W'($urandom_range(0, tick_step_max));
    endcase
    send_item(frame_end(cur_tick), 1'b0, none);
  endtask

  always @(negedge clk) begin
    out_ch.ready = rst_n && ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    tzbm_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_buttons.size() == 0) begin
        report_mismatch($sformatf("unexpected result buttons=%h", out_ch.buttons));
      end else begin
        want = pending_buttons.pop_front();
        if (out_ch.buttons !== want.buttons)
          report_mismatch($sformatf("buttons got %h exp %h", out_ch.buttons, want.buttons));
        if (out_ch.left_active !== want.l_on)
          report_mismatch($sformatf("left_active got %b exp %b", out_ch.left_active, want.l_on));
        if (out_ch.right_active !== want.r_on)
          report_mismatch($sformatf("right_active got %b exp %b", out_ch.right_active,
                                    want.r_on));
      end
    end
  end

  initial begin
    int unsigned phase, phase_start;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = tzbm_pkg::CMD_TOUCH;
    in_ch.touch_id = '0;
    in_ch.x_pos    = '0;
    in_ch.now_tick = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = tzbm_pkg::REG_LEFT_MASK;
    cfg_ch.data    = '0;
    send_idle_pct  = 0;
    rcv_stall_pct  = 0;
    mismatch_cnt   = 0;
    items_sent     = 0;
    cur_tick       = '0;
    zone_cfg       = '{tzbm_pkg::LEFT_MASK_RST, tzbm_pkg::RIGHT_MASK_RST,
                       tzbm_pkg::SPLIT_X_RST, tzbm_pkg::MIN_TICKS_RST};
    wait_rel       = 1'b1;
    l_trk          = 1'b0;
    r_trk          = 1'b0;
    l_fid          = '0;
    r_fid          = '0;
    l_start        = '0;
    r_start        = '0;
    frame_cnt      = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed frames at reset settings
    dir_rows.push_back('{touch(32'd5, 12'd100), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'd1000), 1'b1, '{32'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{frame_end(64'd1001), 1'b1, '{32'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{touch(32'd0, 12'd0), 1'b0, '0});
    dir_rows.push_back('{touch(32'hFFFF_FFFF, 12'hFFF), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'd1), 1'b1, '{32'd3, 1'b1, 1'b1}});
    dir_rows.push_back('{frame_end(64'd2), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'hFFFF_FFFF_FFFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{touch(32'd7, 12'd639), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'd0), 1'b1, '{32'd2, 1'b1, 1'b0}});
    dir_rows.push_back('{frame_end(64'd5), 1'b0, '0});
    dir_rows.push_back('{touch(32'd9, 12'd640), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'hFFFF_FFFF_FFFF_FFF0), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'h10), 1'b0, '0});
    dir_rows.push_back('{touch(32'd3, 12'd5), 1'b0, '0});
    dir_rows.push_back('{touch(32'd3, 12'd900), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'd100), 1'b0, '0});
    dir_rows.push_back('{touch(32'd3, 12'd5), 1'b0, '0});
    dir_rows.push_back('{touch(32'd4, 12'd5), 1'b0, '0});
    dir_rows.push_back('{touch(32'd8, 12'd2000), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'd200), 1'b0, '0});
    dir_rows.push_back('{frame_end(64'd300), 1'b0, '0});
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want);

    phase = 0;
    while (items_sent < 1800) begin
      start_phase(phase);
      phase_start = items_sent;
      while (items_sent - phase_start < 225) begin
        send_frame();
        if ($urandom_range(99) < 2) settle();
      end
      phase++;
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_buttons.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("touch_zone_button_mapper: match");
    end else begin
      $display("touch_zone_button_mapper: mismatch");
    end
    $finish;
  end

endmodule

// ===== touch_zone_button_mapper.f =====
design/tzbm_pkg.sv
design/tzbm_in_if.sv
design/tzbm_out_if.sv
design/tzbm_cfg_if.sv
design/tzbm_cfg_regs.sv
design/tzbm_touch_acc.sv
design/tzbm_tracker.sv
design/touch_zone_button_mapper.sv
sim/touch_zone_button_mapper_tb.sv
